>>> rtl/core/utbl_pkg.sv
`default_nettype none
package utbl_pkg;

   // Table size: one cell per slot, ids are one-based.
   localparam int unsigned SOCKETS = 4;
   localparam int unsigned ID_W = 4;
   localparam int unsigned PORT_W = 16;
   localparam logic [ID_W-1:0] SOCKETS_ID = ID_W'(SOCKETS);
   localparam logic [ID_W-1:0] NO_ID = '0;

   // Ephemeral port range: counter runs over EPH_FIRST .. EPH_WRAP-1.
   localparam logic [PORT_W-1:0] EPH_FIRST = 16'd1024;
   localparam logic [PORT_W-1:0] EPH_WRAP = 16'd49999;

   // Operation codes.
   localparam logic [1:0] OP_OPEN = 2'd0;
   localparam logic [1:0] OP_CLOSE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;

   // Status codes.
   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_PORT_USED = 3'd1;
   localparam logic [2:0] STATUS_NO_SLOT = 3'd2;
   localparam logic [2:0] STATUS_INVALID = 3'd3;
   localparam logic [2:0] STATUS_UNREACH = 3'd4;

   // Token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic              valid;
      logic [PORT_W-1:0] key;       // port to match
      logic [ID_W-1:0]   target;    // slot whose contents are read
      logic [ID_W-1:0]   hit_id;    // first used slot holding key, 0 if none
      logic              hit_ck;
      logic [ID_W-1:0]   free_id;   // first free slot, 0 if none
      logic [PORT_W-1:0] sel_port;  // contents of target slot
      logic              sel_ck;
   } token_type;

   // Write to one slot, broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [ID_W-1:0]   id;
      logic              used;
      logic [PORT_W-1:0] port;
      logic              ck;
   } slot_write_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ID_W-1:0]   id;
      logic [PORT_W-1:0] port;
      logic              ck;
   } result_type;

   // Step the ephemeral counter, wrapping back to the bottom of the range.
   function automatic logic [PORT_W-1:0] eph_advance(input logic [PORT_W-1:0] c);
      logic [PORT_W:0] n;
      n = {1'b0, c} + 17'd1;
      if (n >= {1'b0, EPH_WRAP} || n < {1'b0, EPH_FIRST}) begin
         eph_advance = EPH_FIRST;
      end else begin
         eph_advance = n[PORT_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/utbl_if.sv
`default_nettype none
interface utbl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] port;
   logic        checksum_option;
   logic [3:0]  socket_id;

   modport source (output valid, operation, port, checksum_option, socket_id,
                   input ready);
   modport sink (input valid, operation, port, checksum_option, socket_id,
                 output ready);
endinterface

interface utbl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  socket_id_res;
   logic [15:0] port_res;
   logic        checksum_option_res;

   modport source (output valid, status, socket_id_res, port_res, checksum_option_res,
                   input ready);
   modport sink (input valid, status, socket_id_res, port_res, checksum_option_res,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/core/utbl_cell.sv
`default_nettype none
module utbl_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [utbl_pkg::ID_W-1:0]     cell_id,
   input  wire utbl_pkg::slot_write_type      wr,
   input  wire utbl_pkg::token_type           tok_in,
   output utbl_pkg::token_type                tok_out
);

   logic                        used_ff;
   logic [utbl_pkg::PORT_W-1:0] port_ff;
   logic                        ck_ff;
   utbl_pkg::token_type         tok_ff, tok_in_n;
   logic                        match;

   assign match = used_ff && (port_ff == tok_in.key);

   always_comb begin
      tok_in_n = tok_in;
      if (match && tok_in.hit_id == utbl_pkg::NO_ID) begin
         tok_in_n.hit_id = cell_id;
         tok_in_n.hit_ck = ck_ff;
      end
      if (!used_ff && tok_in.free_id == utbl_pkg::NO_ID) begin
         tok_in_n.free_id = cell_id;
      end
      if (tok_in.target == cell_id) begin
         tok_in_n.sel_port = port_ff;
         tok_in_n.sel_ck = ck_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         port_ff <= '0;
         ck_ff <= 1'b0;
      end else if (wr.en && wr.id == cell_id) begin
         used_ff <= wr.used;
         port_ff <= wr.port;
         ck_ff <= wr.ck;
      end
   end

   // Advance the token one cell per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

>>> rtl/core/utbl_chain.sv
`default_nettype none
module utbl_chain (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire utbl_pkg::slot_write_type wr,
   input  wire utbl_pkg::token_type      tok_in,
   output utbl_pkg::token_type           tok_out
);

   utbl_pkg::token_type tok [0:utbl_pkg::SOCKETS];

   assign tok[0] = tok_in;

   for (genvar k = 0; k < utbl_pkg::SOCKETS; k++) begin : g_cell
      utbl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (utbl_pkg::ID_W'(k + 1)),
         .wr      (wr),
         .tok_in  (tok[k]),
         .tok_out (tok[k+1])
      );
   end

   assign tok_out = tok[utbl_pkg::SOCKETS];

endmodule
`default_nettype wire

>>> rtl/core/udp_port_socket_table_unit.sv
// Search: close, and a read port with a bad socket id, answer without a search; open,
//   lookup and read port are answered once one token has walked the row of slot
//   cells; an ephemeral open sends a further token down the row for each held candidate.
// Throughput: one request at a time; the next is taken once the previous answer is
//   staged in the response register, which may still be waiting on the sink.
// Reset: synchronous, active high; clears every slot and sets the ephemeral counter to 1024.
`default_nettype none
module udp_port_socket_table_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   utbl_req_if.sink   req_chan,
   utbl_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Request held for the whole operation.
   logic [1:0]                  op_ff, op_in;
   logic [utbl_pkg::PORT_W-1:0] port_ff, port_in;
   logic                        ck_ff, ck_in;
   logic [utbl_pkg::ID_W-1:0]   id_ff, id_in;

   logic [utbl_pkg::PORT_W-1:0] eph_ff, eph_in;
   utbl_pkg::result_type        res_ff, res_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   utbl_pkg::result_type        rsp_ff, rsp_in;

   utbl_pkg::token_type         tok_launch, tok_exit;
   utbl_pkg::slot_write_type    wr;

   logic                        accept, rsp_free, id_bad, eph_mode;
   logic [utbl_pkg::PORT_W-1:0] eph_start;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign id_bad = (req_chan.socket_id == utbl_pkg::NO_ID)
                   || (req_chan.socket_id > utbl_pkg::SOCKETS_ID);
   assign eph_mode = (op_ff == utbl_pkg::OP_OPEN) && (port_ff == '0);

   // Pull the counter back into range before the search starts.
   assign eph_start = (eph_ff < utbl_pkg::EPH_FIRST || eph_ff >= utbl_pkg::EPH_WRAP)
                      ? utbl_pkg::EPH_FIRST : eph_ff;

   utbl_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .tok_in  (tok_launch),
      .tok_out (tok_exit)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      port_in = port_ff;
      ck_in = ck_ff;
      id_in = id_ff;
      eph_in = eph_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;

      tok_launch = '0;
      wr = '0;

      // Drop the response once the sink takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_chan.operation;
               port_in = req_chan.port;
               ck_in = req_chan.checksum_option;
               id_in = req_chan.socket_id;
               if ((req_chan.operation == utbl_pkg::OP_CLOSE
                    || req_chan.operation == utbl_pkg::OP_READ) && id_bad) begin
                  res_in = '{utbl_pkg::STATUS_INVALID, utbl_pkg::NO_ID, '0, 1'b0};
                  state_in = ST_DONE;
               end else if (req_chan.operation == utbl_pkg::OP_CLOSE) begin
                  // Close needs no search: clear the slot straight away.
                  wr = '{1'b1, req_chan.socket_id, 1'b0, '0, 1'b0};
                  res_in = '{utbl_pkg::STATUS_OK, req_chan.socket_id, '0, 1'b0};
                  state_in = ST_DONE;
               end else begin
                  // Launch a token down the row of cells.
                  tok_launch.valid = 1'b1;
                  tok_launch.key = (req_chan.operation == utbl_pkg::OP_OPEN
                                    && req_chan.port == '0) ? eph_start : req_chan.port;
                  tok_launch.target = req_chan.socket_id;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (tok_exit.valid) begin
               state_in = ST_DONE;
               case (op_ff)
                  utbl_pkg::OP_OPEN: begin
                     if (eph_mode && tok_exit.hit_id != utbl_pkg::NO_ID) begin
                        // Candidate held: step on and search again.
                        tok_launch.valid = 1'b1;
                        tok_launch.key = utbl_pkg::eph_advance(tok_exit.key);
                        tok_launch.target = id_ff;
                        state_in = ST_SCAN;
                     end else if (tok_exit.hit_id != utbl_pkg::NO_ID) begin
                        res_in = '{utbl_pkg::STATUS_PORT_USED, utbl_pkg::NO_ID, '0, 1'b0};
                     end else begin
                        if (eph_mode) begin
                           eph_in = utbl_pkg::eph_advance(tok_exit.key);
                        end
                        if (tok_exit.free_id != utbl_pkg::NO_ID) begin
                           wr = '{1'b1, tok_exit.free_id, 1'b1, tok_exit.key, ck_ff};
                           res_in = '{utbl_pkg::STATUS_OK, tok_exit.free_id,
                                      tok_exit.key, ck_ff};
                        end else begin
                           res_in = '{utbl_pkg::STATUS_NO_SLOT, utbl_pkg::NO_ID, '0, 1'b0};
                        end
                     end
                  end
                  utbl_pkg::OP_LOOKUP: begin
                     if (tok_exit.hit_id != utbl_pkg::NO_ID) begin
                        res_in = '{utbl_pkg::STATUS_OK, tok_exit.hit_id, tok_exit.key,
                                   tok_exit.hit_ck};
                     end else begin
                        res_in = '{utbl_pkg::STATUS_UNREACH, utbl_pkg::NO_ID, '0, 1'b0};
                     end
                  end
                  default: begin
                     // Read port: the target cell dropped its contents into the token.
                     res_in = '{utbl_pkg::STATUS_OK, id_ff, tok_exit.sel_port,
                                tok_exit.sel_ck};
                  end
               endcase
            end
         end

         ST_DONE: begin
            // Hold the result until the response register is free.
            if (rsp_free) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         eph_ff <= utbl_pkg::EPH_FIRST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         eph_ff <= eph_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      port_ff <= port_in;
      ck_ff <= ck_in;
      id_ff <= id_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_ff.status;
   assign rsp_chan.socket_id_res = rsp_ff.id;
   assign rsp_chan.port_res = rsp_ff.port;
   assign rsp_chan.checksum_option_res = rsp_ff.ck;

   // A token leaves the row only while a search is in progress.
   a_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_exit.valid |-> (state_ff == ST_SCAN))
      else $error("token left the cell row outside a search");

   // The ephemeral counter stays within its range.
   a_eph_range: assert property (@(posedge clock) disable iff (reset)
      (eph_ff >= utbl_pkg::EPH_FIRST) && (eph_ff < utbl_pkg::EPH_WRAP))
      else $error("ephemeral counter out of range");

   // One request at a time: a taken request blocks the next one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("request accepted while another is in progress");

   // A response is only loaded when the register was free or being emptied.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending response overwritten");

endmodule
`default_nettype wire
